// File: rtl/core/base64_stream_decoder_unit_macros.svh
// assertion macros for the base64 stream decoder
// no dependencies; included by the top level only
`ifndef BASE64_STREAM_DECODER_UNIT_MACROS_SVH
`define BASE64_STREAM_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define B64SD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, disabled while in reset
`define B64SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define B64SD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define B64SD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/b64sd_pkg.sv
// shared types, constants and the sextet lookup for the base64 decoder
// no dependencies
package b64sd_pkg;

  // character codes of the alphabet ranges
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChSlash  = 8'h2F;

  // sextet offsets of the lower case and digit ranges, and the codes of plus and slash
  localparam logic [5:0] LowerBase = 6'd26;
  localparam logic [5:0] DigitBase = 6'd52;
  localparam logic [5:0] PlusCode  = 6'd62;
  localparam logic [5:0] SlashCode = 6'd63;

  localparam int unsigned SextetW = 6;
  localparam int unsigned HeldW   = 3 * SextetW;
  localparam int unsigned WordW   = 4 * SextetW;

  // job queue sizing
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = QPtrW + 1;

  // one decoded group handed from the front to the back
  typedef struct packed {
    logic [WordW-1:0] word;    // bytes, first in the high bits
    logic [1:0]       nbytes;  // 0 to 3 valid bytes
    logic             done;    // group closes the string
  } job_t;

  // queue status seen by both sides
  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } q_status_t;

  // map a character to {is_alphabet, sextet}
  function automatic logic [SextetW:0] sextet_of(input logic [7:0] c);
    logic [SextetW:0] r;
    r = '0;
    if (c >= ChUpperA && c <= ChUpperZ) begin
      r = {1'b1, 6'(c - ChUpperA)};
    end else if (c >= ChLowerA && c <= ChLowerZ) begin
      r = {1'b1, 6'(c - ChLowerA) + LowerBase};
    end else if (c >= ChDigit0 && c <= ChDigit9) begin
      r = {1'b1, 6'(c - ChDigit0) + DigitBase};
    end else if (c == ChPlus) begin
      r = {1'b1, PlusCode};
    end else if (c == ChSlash) begin
      r = {1'b1, SlashCode};
    end
    return r;
  endfunction

endpackage

// File: rtl/core/b64sd_front.sv
// front end: accepts characters, gathers sextets and forms byte jobs
// depends on b64sd_pkg
module b64sd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        char_code_i,
  input  logic              string_end_i,
  input  b64sd_pkg::q_status_t q_stat_i,
  output logic              push_o,
  output b64sd_pkg::job_t   job_o
);
  import b64sd_pkg::*;

  logic [1:0]       group_count_q, group_count_d;
  logic [HeldW-1:0] held_q, held_d;
  logic             stopped_q, stopped_d;
  logic             accept;
  logic [SextetW:0] lookup;
  job_t             job;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign lookup     = sextet_of(char_code_i);

  // next state and job for the current character
  always_comb begin
    group_count_d = group_count_q;
    held_d        = held_q;
    stopped_d     = stopped_q;
    job           = '0;
    if (!stopped_q) begin
      if (!lookup[SextetW]) begin
        stopped_d = 1'b1;
      end else if (group_count_q == 2'd3) begin
        job.word      = {held_q, lookup[SextetW-1:0]};
        job.nbytes    = 2'd3;
        group_count_d = 2'd0;
        held_d        = '0;
      end else begin
        held_d        = {held_q[HeldW-SextetW-1:0], lookup[SextetW-1:0]};
        group_count_d = group_count_q + 2'd1;
      end
    end
    // end of string flushes the partial group
    if (string_end_i) begin
      if (job.nbytes == 2'd0) begin
        if (group_count_d == 2'd2) begin
          job.word   = {held_d[2*SextetW-1:0], {(2*SextetW){1'b0}}};
          job.nbytes = 2'd1;
        end else if (group_count_d == 2'd3) begin
          job.word   = {held_d, {SextetW{1'b0}}};
          job.nbytes = 2'd2;
        end
      end
      job.done      = 1'b1;
      group_count_d = 2'd0;
      held_d        = '0;
      stopped_d     = 1'b0;
    end
  end

  assign push_o = accept && (job.nbytes != 2'd0 || job.done);
  assign job_o  = job;

  // group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_count_q <= 2'd0;
      held_q        <= '0;
      stopped_q     <= 1'b0;
    end else if (accept) begin
      group_count_q <= group_count_d;
      held_q        <= held_d;
      stopped_q     <= stopped_d;
    end
  end

endmodule

// File: rtl/core/b64sd_queue.sv
// short job queue between front and back, held in flops
// depends on b64sd_pkg
module b64sd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  b64sd_pkg::job_t      job_i,
  input  logic                 pop_i,
  output b64sd_pkg::job_t      head_o,
  output b64sd_pkg::q_status_t stat_o
);
  import b64sd_pkg::*;

  job_t             store_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;

  assign head_o       = store_q[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.full  = (count_q == QCntW'(QDepth));
  assign stat_o.empty = (count_q == '0);

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= job_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

endmodule

// File: rtl/core/b64sd_back.sv
// back end: splits each job into byte transactions behind an output register
// depends on b64sd_pkg
module b64sd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  b64sd_pkg::job_t      head_i,
  input  b64sd_pkg::q_status_t q_stat_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           data_byte_o,
  output logic                 byte_valid_o,
  output logic                 run_last_o,
  output logic                 string_done_o
);
  import b64sd_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q;
  logic [7:0] data_q;
  logic       bvalid_q, last_q, done_q;
  logic       load, last;
  logic [1:0] final_idx;
  logic [7:0] sel_byte;

  // pick the byte of the head job at the current index
  always_comb begin
    unique case (idx_q)
      2'd0:    sel_byte = head_i.word[WordW-1 -: 8];
      2'd1:    sel_byte = head_i.word[WordW-9 -: 8];
      default: sel_byte = head_i.word[7:0];
    endcase
  end

  assign final_idx = (head_i.nbytes == 2'd0) ? 2'd0 : head_i.nbytes - 2'd1;
  assign last      = (idx_q == final_idx);
  assign load      = !q_stat_i.empty && (!out_valid_q || !out_stall_i);
  assign pop_o     = load && last;
  assign idx_d     = last ? 2'd0 : idx_q + 2'd1;

  // byte index within the head job, and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= idx_d;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q   <= (head_i.nbytes == 2'd0) ? 8'd0 : sel_byte;
      bvalid_q <= (head_i.nbytes != 2'd0);
      last_q   <= last;
      done_q   <= last && head_i.done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_byte_o   = data_q;
  assign byte_valid_o  = bvalid_q;
  assign run_last_o    = last_q;
  assign string_done_o = done_q;

endmodule

// File: rtl/core/base64_stream_decoder_unit.sv
// Base64 stream decoder: one character per cycle in and one byte transaction per cycle out, unless stalled.
// Path: the front end forms jobs into the job queue, and the back end loads each byte into its output register.
// Throughput: one character per cycle; the back end gives one result per cycle while the receiver does not stall, and
// input stalls only when the four-entry job queue is full.
// Reset: asynchronous, active low; clears group state, queue pointers and output valid.
// depends on b64sd_pkg, b64sd_front, b64sd_queue, b64sd_back and the macros header
`include "base64_stream_decoder_unit_macros.svh"
module base64_stream_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       string_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       string_done_o
);
  import b64sd_pkg::*;

  logic      push, pop;
  job_t      push_job, head_job;
  q_status_t q_stat;

  // character intake and grouping
  b64sd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_code_i  (char_code_i),
    .string_end_i (string_end_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .job_o        (push_job)
  );

  // job queue
  b64sd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .head_o (head_job),
    .stat_o (q_stat)
  );

  // byte output
  b64sd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_job),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_byte_o   (data_byte_o),
    .byte_valid_o  (byte_valid_o),
    .run_last_o    (run_last_o),
    .string_done_o (string_done_o)
  );

  // an empty result only closes a string
  `B64SD_ASSERT_NOW(a_empty_is_done, clk_i, rst_ni, out_valid_o && !byte_valid_o, string_done_o && run_last_o && data_byte_o == 8'd0)
  // string done always ends the run of its character
  `B64SD_ASSERT_NOW(a_done_is_last, clk_i, rst_ni, out_valid_o && string_done_o, run_last_o)
  // queue fill level stays within its depth
  `B64SD_ASSERT_NOW(a_queue_bound, clk_i, rst_ni, 1'b1, q_stat.count <= QCntW'(QDepth))
  // a push into a full queue cannot happen
  `B64SD_ASSERT_NEXT(a_no_overflow, clk_i, rst_ni, q_stat.full && !pop, !(push && $past(q_stat.full)) || $past(pop))

endmodule

// File: tb/sv/tb_b64_decode_pkg.sv
// expected-byte tracking for the base64 stream decoder testbench
// holds the alphabet helpers and the decode tracker class; depends on b64sd_pkg
package tb_b64_decode_pkg;
  import b64sd_pkg::*;

  // padding character, first of the stop characters
  localparam logic [7:0] ChPad = 8'h3D;

  // one decoded result as seen on the output port
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       done;
  } dec_result_t;

  // alphabet lookup: {is_alphabet, sextet}
  function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= ChUpperA && c <= ChUpperZ) r = {1'b1, 6'(c - ChUpperA)};
    else if (c >= ChLowerA && c <= ChLowerZ) r = {1'b1, 6'(c - ChLowerA + 8'd26)};
    else if (c >= ChDigit0 && c <= ChDigit9) r = {1'b1, 6'(c - ChDigit0 + 8'd52)};
    else if (c == ChPlus) r = {1'b1, 6'd62};
    else if (c == ChSlash) r = {1'b1, 6'd63};
    return r;
  endfunction

  // inverse mapping, used to build well-formed strings
  function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26) c = ChUpperA + 8'(s);
    else if (s < 6'd52) c = ChLowerA + 8'(s - 6'd26);
    else if (s < 6'd62) c = ChDigit0 + 8'(s - 6'd52);
    else if (s == 6'd62) c = ChPlus;
    else c = ChSlash;
    return c;
  endfunction

  // random byte outside the alphabet, padding half of the time
  function automatic logic [7:0] random_stop_char();
    logic [7:0] c;
    logic [6:0] m;
    if ($urandom_range(0, 1) == 0) return ChPad;
    do begin
      c = 8'($urandom_range(0, 255));
      m = char_to_sextet(c);
    end while (m[6]);
    return c;
  endfunction

  class b64_decode_tracker;
    dec_result_t pending_bytes[$];
    logic [1:0]  group_cnt;
    logic [17:0] held;
    logic        halted;
    int unsigned errors;
    int unsigned n_checked;
    int unsigned n_strings;
    int unsigned n_empty;
    int unsigned n_stops;

    function new();
      group_cnt = '0;
      held      = '0;
      halted    = 1'b0;
      errors    = 0;
      n_checked = 0;
      n_strings = 0;
      n_empty   = 0;
      n_stops   = 0;
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction

    // predict the results of one accepted character; returns 1 if it was not ignored
    function bit absorb_char(input logic [7:0] c, input logic str_end);
      dec_result_t res[$];
      dec_result_t r;
      logic [6:0]  m;
      logic [23:0] w;
      bit          live;
      live = !halted || str_end;
      m = char_to_sextet(c);
      // sextet gathering until the first stop character
      if (!halted) begin
        if (!m[6]) begin
          halted = 1'b1;
          n_stops++;
        end else if (group_cnt == 2'd3) begin
          w = {held, m[5:0]};
          r = '{data: w[23:16], valid: 1'b1, last: 1'b0, done: 1'b0};
          res.push_back(r);
          r.data = w[15:8];
          res.push_back(r);
          r.data = w[7:0];
          res.push_back(r);
          group_cnt = '0;
          held = '0;
        end else begin
          held = {held[11:0], m[5:0]};
          group_cnt++;
        end
      end
      // end of string: flush the partial group, then back to idle
      if (str_end) begin
        r = '{data: 8'h00, valid: 1'b1, last: 1'b0, done: 1'b0};
        if (group_cnt == 2'd2) begin
          w = {held[11:0], 12'h000};
          r.data = w[23:16];
          res.push_back(r);
        end else if (group_cnt == 2'd3) begin
          w = {held, 6'h00};
          r.data = w[23:16];
          res.push_back(r);
          r.data = w[15:8];
          res.push_back(r);
        end
        if (res.size() == 0) begin
          r.valid = 1'b0;
          res.push_back(r);
          n_empty++;
        end
        res[res.size()-1].done = 1'b1;
        group_cnt = '0;
        held = '0;
        halted = 1'b0;
        n_strings++;
      end
      if (res.size() > 0) res[res.size()-1].last = 1'b1;
      foreach (res[i]) pending_bytes.push_back(res[i]);
      return live;
    endfunction

    task report(input string what);
      errors++;
      if (errors <= 40) $display("%0t mismatch: %s", $realtime, what);
    endtask

    // compare one output transaction against the oldest expectation
    task match_byte(input dec_result_t got);
      dec_result_t want;
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected result data=%02h valid=%0b last=%0b done=%0b",
                         got.data, got.valid, got.last, got.done));
        return;
      end
      want = pending_bytes.pop_front();
      n_checked++;
      if (got.data !== want.data)
        report($sformatf("data_byte %02h, want %02h", got.data, want.data));
      if (got.valid !== want.valid)
        report($sformatf("byte_valid %0b, want %0b", got.valid, want.valid));
      if (got.last !== want.last)
        report($sformatf("run_last %0b, want %0b", got.last, want.last));
      if (got.done !== want.done)
        report($sformatf("string_done %0b, want %0b", got.done, want.done));
    endtask
  endclass

endpackage

// File: tb/sv/tb_base64_stream_decoder_unit.sv
// top-level testbench for base64_stream_decoder_unit
// drives characters with bursts and gaps, stalls the output, checks via tb_b64_decode_pkg
module tb_base64_stream_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import b64sd_pkg::*;
  import tb_b64_decode_pkg::*;

  localparam int unsigned RandomItems = 500;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned SettleCycles = 16;

  logic       clk_i;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic [7:0] char_code_i  = 8'h00;
  logic       string_end_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic [7:0] data_byte_o;
  logic       byte_valid_o;
  logic       run_last_o;
  logic       string_done_o;

  b64_decode_tracker tracker = new();
  int unsigned burst_left = 0;
  int unsigned live_items = 0;
  int unsigned cycles = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_run = 0;
  int unsigned n_drains = 0;

  base64_stream_decoder_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_code_i  (char_code_i),
    .string_end_i (string_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_byte_o  (data_byte_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .string_done_o(string_done_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stall pattern, with a randomly picked mode
  always @(posedge clk_i) begin
    if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= 1'($urandom_range(0, 1));
      2: out_stall_i <= (cycles % 4 != 0);
      default: begin
        if (stall_run == 0) begin
          stall_run   <= $urandom_range(1, 12);
          out_stall_i <= ~out_stall_i;
        end else begin
          stall_run <= stall_run - 1;
        end
      end
    endcase
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.match_byte('{data: data_byte_o, valid: byte_valid_o,
                           last: run_last_o, done: string_done_o});
  end

  // sender idle for a pause whose length is n
  task automatic pause(input int unsigned n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // hold the sender until every expected result has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    n_drains++;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  // one character transaction, with burst and gap shaping
  task automatic send_char(input logic [7:0] c, input logic str_end);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      pause(gap);
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    char_code_i  <= c;
    string_end_i <= str_end;
    do @(posedge clk_i); while (in_stall_o);
    if (tracker.absorb_char(c, str_end)) live_items++;
  endtask

  task automatic send_string(input logic [7:0] chars[$]);
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  // well-formed strings mostly, then broken ones and plain noise
  task automatic send_random_string();
    logic [7:0]  chars[$];
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      n = $urandom_range(1, 24);
      repeat (n) chars.push_back(sextet_to_char(6'($urandom_range(0, 63))));
      if (n % 4 >= 2 && $urandom_range(0, 1) == 1)
        repeat (4 - n % 4) chars.push_back(ChPad);
    end else if (kind < 85) begin
      repeat ($urandom_range(0, 10))
        chars.push_back(sextet_to_char(6'($urandom_range(0, 63))));
      chars.push_back(random_stop_char());
      repeat ($urandom_range(0, 5)) chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 8)) chars.push_back(8'($urandom_range(0, 255)));
    end
    send_string(chars);
  endtask

  // main sequence
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: range edges with two full groups ending the string
    send_string('{ChUpperA, ChUpperZ, ChLowerA, ChLowerZ,
                  ChDigit0, ChDigit9, ChPlus, ChSlash});
    // padded strings giving one and two bytes
    send_string('{8'h51, 8'h51, ChPad, ChPad});
    send_string('{8'h51, 8'h55, 8'h49, ChPad});
    // lone sextet flushes to nothing
    send_string('{8'h51});
    // zero byte stops, later characters ignored, top byte ends
    send_string('{ChUpperA, 8'h42, 8'h00, 8'h43, 8'hFF});
    // stop character that also ends the string
    send_string('{8'h80});
    drain();

    // random strings
    live_items = 0;
    while (live_items < RandomItems) begin
      send_random_string();
      if ($urandom_range(0, 39) == 0) drain();
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    $display("covered %0d strings, %0d results checked, %0d empty flushes, %0d stops",
             tracker.n_strings, tracker.n_checked, tracker.n_empty, tracker.n_stops);
    $display("sender drained %0d times, %0d mismatches", n_drains, tracker.errors);
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
